// ===== src/rdiff_pkg.sv =====
package rdiff_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int NUM_BANDS   = 4;
    // words held per queue entry: ax ay aw h0 ovy w1 ovh x2 w2 y3 h3
    localparam int ENTRY_WORDS = 11;

    typedef enum logic [1:0] {
        BAND_ABOVE = 2'd0,
        BAND_LEFT  = 2'd1,
        BAND_RIGHT = 2'd2,
        BAND_BELOW = 2'd3
    } band_t;

    typedef struct packed {
        logic              not_empty;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

endpackage

// ===== src/rdiff_front.sv =====
module rdiff_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [COORD_BITS-1:0]           a_x,
    input  logic signed [COORD_BITS-1:0]           a_y,
    input  logic signed [COORD_BITS-1:0]           a_w,
    input  logic signed [COORD_BITS-1:0]           a_h,
    input  logic signed [COORD_BITS-1:0]           b_x,
    input  logic signed [COORD_BITS-1:0]           b_y,
    input  logic signed [COORD_BITS-1:0]           b_w,
    input  logic signed [COORD_BITS-1:0]           b_h,
    input  rdiff_pkg::queue_status_t               q_stat,
    output logic                                   q_wr,
    output logic [rdiff_pkg::ENTRY_WORDS*COORD_BITS+rdiff_pkg::NUM_BANDS-1:0] q_data
);

    localparam int W = COORD_BITS;
    localparam int QCNT_W_EXT = rdiff_pkg::QCNT_W + 1;

    function automatic logic is_pos(input logic [COORD_BITS-1:0] v);
        return !v[COORD_BITS-1] && (v != '0);
    endfunction

    logic                s1_valid_reg;
    logic signed [W-1:0] ax_reg, ay_reg, aw_reg, ah_reg, ovx_reg, ovy_reg;
    logic signed [W:0]   aex_reg, aey_reg, ex_reg, ey_reg;
    logic                a_ok_reg, b_ok_reg;

    logic                accept;
    logic signed [W:0]   aex_sum, aey_sum, bex_sum, bey_sum;
    logic [QCNT_W_EXT-1:0] occupancy;

    logic [W-1:0] ovw, ovh, h0, w1, x2, w2, y3, h3;
    logic         have_ov;
    logic [rdiff_pkg::NUM_BANDS-1:0] mask;

    assign occupancy = QCNT_W_EXT'(q_stat.count) + QCNT_W_EXT'(s1_valid_reg);
    assign busy      = occupancy >= QCNT_W_EXT'(rdiff_pkg::QUEUE_DEPTH);
    assign accept    = start && !busy;

    assign aex_sum = (W+1)'(a_x) + (W+1)'(a_w);
    assign aey_sum = (W+1)'(a_y) + (W+1)'(a_h);
    assign bex_sum = (W+1)'(b_x) + (W+1)'(b_w);
    assign bey_sum = (W+1)'(b_y) + (W+1)'(b_h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg   <= a_x;
            ay_reg   <= a_y;
            aw_reg   <= a_w;
            ah_reg   <= a_h;
            aex_reg  <= aex_sum;
            aey_reg  <= aey_sum;
            ex_reg   <= (aex_sum < bex_sum) ? aex_sum : bex_sum;
            ey_reg   <= (aey_sum < bey_sum) ? aey_sum : bey_sum;
            ovx_reg  <= (a_x > b_x) ? a_x : b_x;
            ovy_reg  <= (a_y > b_y) ? a_y : b_y;
            a_ok_reg <= is_pos(a_w) && is_pos(a_h);
            b_ok_reg <= is_pos(b_w) && is_pos(b_h);
        end
    end

    // overlap extents and band candidates, all modulo 2^W
    always_comb
    begin
        ovw     = ex_reg[W-1:0] - ovx_reg;
        ovh     = ey_reg[W-1:0] - ovy_reg;
        have_ov = a_ok_reg && b_ok_reg && is_pos(ovw) && is_pos(ovh);
        h0      = have_ov ? (ovy_reg - ay_reg) : ah_reg;
        w1      = ovx_reg - ax_reg;
        x2      = ex_reg[W-1:0];
        w2      = aex_reg[W-1:0] - ex_reg[W-1:0];
        y3      = ey_reg[W-1:0];
        h3      = aey_reg[W-1:0] - ey_reg[W-1:0];
        if (have_ov)
        begin
            mask = {is_pos(h3), is_pos(w2), is_pos(w1), is_pos(h0)};
        end
        else
        begin
            mask = {3'b000, a_ok_reg};
        end
    end

    assign q_wr   = s1_valid_reg;
    assign q_data = {mask, h3, y3, w2, x2, ovh, w1, ovy_reg, h0, aw_reg, ay_reg, ax_reg};

endmodule

// ===== src/rdiff_queue.sv =====
module rdiff_queue #(
    parameter int ENTRY_W = 180
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr,
    input  logic [ENTRY_W-1:0]       wr_data,
    input  logic                     rd,
    output logic [ENTRY_W-1:0]       rd_data,
    output rdiff_pkg::queue_status_t stat
);

    logic [ENTRY_W-1:0]              entry_reg [rdiff_pkg::QUEUE_DEPTH];
    logic [rdiff_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [rdiff_pkg::QCNT_W-1:0]    count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        case ({wr, rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data        = entry_reg[rd_ptr_reg];
    assign stat.count     = count_reg;
    assign stat.not_empty = (count_reg != '0);

endmodule

// ===== src/rdiff_back.sv =====
module rdiff_back #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rdiff_pkg::queue_status_t               q_stat,
    input  logic [rdiff_pkg::ENTRY_WORDS*COORD_BITS+rdiff_pkg::NUM_BANDS-1:0] q_data,
    output logic                                   q_rd,
    output logic                                   strobe,
    output logic signed [COORD_BITS-1:0]           piece_x,
    output logic signed [COORD_BITS-1:0]           piece_y,
    output logic signed [COORD_BITS-1:0]           piece_w,
    output logic signed [COORD_BITS-1:0]           piece_h,
    output logic [1:0]                             band,
    output logic                                   none_left,
    output logic                                   last
);

    localparam int W       = COORD_BITS;
    localparam int NB      = rdiff_pkg::NUM_BANDS;
    localparam int ENTRY_W = rdiff_pkg::ENTRY_WORDS * COORD_BITS + NB;

    logic [ENTRY_W-1:0] cur_reg;
    logic [NB-1:0]      rem_reg, rem_next;
    logic               none_reg, none_next;
    logic               cur_valid_reg, cur_valid_next;

    logic               strobe_reg;
    logic [W-1:0]       x_reg, y_reg, w_reg, h_reg;
    rdiff_pkg::band_t   band_reg, sel_band;
    logic               none_left_reg, last_reg;

    logic [NB-1:0]      low;
    logic               emit_last;
    logic [W-1:0]       sel_x, sel_y, sel_w, sel_h;
    logic [W-1:0]       ax, ay, aw, h0, ovy, w1, ovh, x2, w2, y3, h3;

    assign ax  = cur_reg[0*W +: W];
    assign ay  = cur_reg[1*W +: W];
    assign aw  = cur_reg[2*W +: W];
    assign h0  = cur_reg[3*W +: W];
    assign ovy = cur_reg[4*W +: W];
    assign w1  = cur_reg[5*W +: W];
    assign ovh = cur_reg[6*W +: W];
    assign x2  = cur_reg[7*W +: W];
    assign w2  = cur_reg[8*W +: W];
    assign y3  = cur_reg[9*W +: W];
    assign h3  = cur_reg[10*W +: W];

    assign low       = rem_reg & (~rem_reg + 1'b1);
    assign emit_last = none_reg || ((rem_reg & ~low) == '0);
    assign q_rd      = q_stat.not_empty && (!cur_valid_reg || emit_last);

    always_comb
    begin
        case (low)
            4'b0010: sel_band = rdiff_pkg::BAND_LEFT;
            4'b0100: sel_band = rdiff_pkg::BAND_RIGHT;
            4'b1000: sel_band = rdiff_pkg::BAND_BELOW;
            default: sel_band = rdiff_pkg::BAND_ABOVE;
        endcase
        case (sel_band)
            rdiff_pkg::BAND_LEFT:
            begin
                sel_x = ax; sel_y = ovy; sel_w = w1; sel_h = ovh;
            end
            rdiff_pkg::BAND_RIGHT:
            begin
                sel_x = x2; sel_y = ovy; sel_w = w2; sel_h = ovh;
            end
            rdiff_pkg::BAND_BELOW:
            begin
                sel_x = ax; sel_y = y3; sel_w = aw; sel_h = h3;
            end
            default:
            begin
                sel_x = ax; sel_y = ay; sel_w = aw; sel_h = h0;
            end
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        rem_next       = rem_reg;
        none_next      = none_reg;
        if (q_rd)
        begin
            cur_valid_next = 1'b1;
            rem_next       = q_data[ENTRY_W-1 -: NB];
            none_next      = (q_data[ENTRY_W-1 -: NB] == '0);
        end
        else if (cur_valid_reg)
        begin
            rem_next = rem_reg & ~low;
            if (emit_last)
            begin
                cur_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            strobe_reg    <= cur_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        none_reg <= none_next;
        if (q_rd)
        begin
            cur_reg <= q_data;
        end
        if (cur_valid_reg)
        begin
            last_reg      <= emit_last;
            none_left_reg <= none_reg;
            if (none_reg)
            begin
                x_reg    <= '0;
                y_reg    <= '0;
                w_reg    <= '0;
                h_reg    <= '0;
                band_reg <= rdiff_pkg::BAND_ABOVE;
            end
            else
            begin
                x_reg    <= sel_x;
                y_reg    <= sel_y;
                w_reg    <= sel_w;
                h_reg    <= sel_h;
                band_reg <= sel_band;
            end
        end
    end

    assign strobe    = strobe_reg;
    assign piece_x   = x_reg;
    assign piece_y   = y_reg;
    assign piece_w   = w_reg;
    assign piece_h   = h_reg;
    assign band      = band_reg;
    assign none_left = none_left_reg;
    assign last      = last_reg;

endmodule

// ===== src/rectangle_difference.sv =====
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+---------------------------------
// input     | a_x a_y a_w a_h b_x b_y b_w b_h          | word taken when start && !busy
// result    | piece_x piece_y piece_w piece_h band     | one word per cycle on strobe
//           | none_left last                          |
//
// Each input word yields one to four result words, one per cycle; a new input
// word is taken every cycle while the four-entry queue has room.
// The first result word passes the classify stage, the queue and the current-word register
// before it is registered and strobed; sustained rate is set by the piece count per word.
// rst_n clears the pipeline valid, the queue pointers and the result strobe.
// The result side cannot stall; busy rises when the queue and the classify
// stage together hold four words.
module rectangle_difference #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic signed [COORD_BITS-1:0] a_w,
    input  logic signed [COORD_BITS-1:0] a_h,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic signed [COORD_BITS-1:0] b_w,
    input  logic signed [COORD_BITS-1:0] b_h,
    output logic                         strobe,
    output logic signed [COORD_BITS-1:0] piece_x,
    output logic signed [COORD_BITS-1:0] piece_y,
    output logic signed [COORD_BITS-1:0] piece_w,
    output logic signed [COORD_BITS-1:0] piece_h,
    output logic [1:0]                   band,
    output logic                         none_left,
    output logic                         last
);

    localparam int ENTRY_W = rdiff_pkg::ENTRY_WORDS * COORD_BITS + rdiff_pkg::NUM_BANDS;

    rdiff_pkg::queue_status_t q_stat;
    logic                     q_wr, q_rd;
    logic [ENTRY_W-1:0]       q_wr_data, q_rd_data;

    rdiff_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .a_x    (a_x),
        .a_y    (a_y),
        .a_w    (a_w),
        .a_h    (a_h),
        .b_x    (b_x),
        .b_y    (b_y),
        .b_w    (b_w),
        .b_h    (b_h),
        .q_stat (q_stat),
        .q_wr   (q_wr),
        .q_data (q_wr_data)
    );

    rdiff_queue #(
        .ENTRY_W(ENTRY_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .rd      (q_rd),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    rdiff_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_data    (q_rd_data),
        .q_rd      (q_rd),
        .strobe    (strobe),
        .piece_x   (piece_x),
        .piece_y   (piece_y),
        .piece_w   (piece_w),
        .piece_h   (piece_h),
        .band      (band),
        .none_left (none_left),
        .last      (last)
    );

    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && none_left |-> last)
        else $error("none_left result without last");

    a_piece_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !none_left |-> !piece_w[COORD_BITS-1] && (piece_w != '0) &&
                                 !piece_h[COORD_BITS-1] && (piece_h != '0))
        else $error("empty piece emitted");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr && !q_rd |-> q_stat.count != rdiff_pkg::QCNT_W'(rdiff_pkg::QUEUE_DEPTH))
        else $error("write into full queue");

    a_pieces_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("gap inside one word's results");

endmodule
